// ===== hw/rtl/tpe_pkg.sv =====
`default_nettype none

package tpe_pkg;

    // Sizing
    localparam int MAX_DEGREE  = 8;
    localparam int COEF_DEPTH  = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
    localparam int NUM_TERMS = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
    localparam int TERM_W    = $clog2(NUM_TERMS);
    localparam int ADDR_W    = $clog2(COEF_DEPTH);
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int CFG_W    = 4;
    localparam int INDEX_W  = 6;
    localparam int COEF_W   = 32;
    localparam int COORD_W  = 25;
    localparam int FRAC_W   = 24;
    localparam int OUT_W    = 48;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int TPROD_W  = COEF_W + COORD_W + 1;
    localparam int ACC_W    = 64;

    localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(1) << FRAC_W;
    localparam logic [PROD_W-1:0]  HALF_PROD = PROD_W'(1) << (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (FRAC_W - 1);

    localparam logic signed [ACC_W-1:0] OUT_MAX =
        {{(ACC_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] OUT_MIN =
        {{(ACC_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } tpe_op_t;

    typedef struct packed {
        tpe_op_t                    op;
        logic [INDEX_W-1:0]         index;
        logic signed [COEF_W-1:0]   value;
        logic [COORD_W-1:0]         s;
        logic [COORD_W-1:0]         t;
        logic [COORD_W-1:0]         u;
    } tpe_item_t;

    typedef struct packed {
        logic      valid;
        tpe_item_t item;
    } tpe_queue_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POWERS,
        ST_TERMS,
        ST_DRAIN,
        ST_FINISH
    } tpe_state_t;

    // Round a Q2.48 product back to Q1.24; inputs never exceed 1.0
    function automatic logic [COORD_W-1:0] round_q(input logic [PROD_W-1:0] prod);
        logic [PROD_W-1:0] sum;
        sum = prod + HALF_PROD;
        return sum[FRAC_W + COORD_W - 1:FRAC_W];
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] x);
        return (x > ONE_Q) ? ONE_Q : x;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tpe_ram.sv =====
`default_nettype none

module tpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tpe_front.sv =====
`default_nettype none

module tpe_front
    import tpe_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      opcode,
    input  wire logic [INDEX_W-1:0]        coef_index,
    input  wire logic signed [COEF_W-1:0]  coef_value,
    input  wire logic [COORD_W-1:0]        s_coord,
    input  wire logic [COORD_W-1:0]        t_coord,
    input  wire logic [COORD_W-1:0]        u_coord,
    output tpe_queue_t                     q_head,
    input  wire logic                      q_pop
);

    tpe_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    tpe_item_t          item_in;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // Classify the beat and clamp coordinates above one
    always_comb
    begin
        item_in.op    = tpe_op_t'(opcode);
        item_in.index = coef_index;
        item_in.value = coef_value;
        item_in.s     = clamp_coord(s_coord);
        item_in.t     = clamp_coord(t_coord);
        item_in.u     = clamp_coord(u_coord);
    end

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;

    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tpe_back.sv =====
`default_nettype none

module tpe_back
    import tpe_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tpe_queue_t               q_head,
    output logic                          q_pop,
    input  wire logic [DEG_W-1:0]         degree,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [OUT_W-1:0]       poly_value,
    output logic                          saturated
);

    tpe_state_t state_reg;
    tpe_state_t state_next;

    // Coefficient store
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [COEF_W-1:0]        ram_rdata;

    // Power tables
    logic [COORD_W-1:0] s_reg, t_reg, u_reg;
    logic [COORD_W-1:0] last_s_reg, last_t_reg, last_u_reg;
    logic [COORD_W-1:0] pow_s_reg [MAX_DEGREE + 1];
    logic [COORD_W-1:0] pow_t_reg [MAX_DEGREE + 1];
    logic [COORD_W-1:0] pow_u_reg [MAX_DEGREE + 1];
    logic [COORD_W-1:0] new_s, new_t, new_u;

    // Term walk
    logic [DEG_W-1:0]   deg_reg, n_reg, i_reg, j_reg;
    logic [TERM_W-1:0]  idx_reg;
    logic               last_term;
    logic               start_eval;

    // Term pipeline
    logic                       p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic [DEG_W-1:0]           p1_i_reg, p1_j_reg, p1_k_reg, p2_k_reg;
    logic                       p1_inr_reg;
    logic [PROD_W-1:0]          p2_prod_reg, p3_prod_reg;
    logic signed [COEF_W-1:0]   p2_coef_reg, p3_coef_reg;
    logic signed [TPROD_W-1:0]  p4_term_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    // Result
    logic signed [ACC_W-1:0]    rounded;
    logic signed [ACC_W-1:0]    quot;
    logic                       sat_hi, sat_lo;
    logic                       out_free;
    logic                       out_valid_reg;
    logic signed [OUT_W-1:0]    poly_value_reg;
    logic                       saturated_reg;

    tpe_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_head.item.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_pop      = (state_reg == ST_IDLE) && q_head.valid;
    assign start_eval = q_pop && (q_head.item.op == OP_EVAL);
    assign ram_we     = q_pop && (q_head.item.op == OP_LOAD)
                        && (int'(q_head.item.index) < COEF_DEPTH);
    assign ram_waddr  = ADDR_W'(q_head.item.index);
    assign ram_raddr  = ADDR_W'(idx_reg);
    assign last_term  = (i_reg == deg_reg);

    assign new_s = round_q(last_s_reg * s_reg);
    assign new_t = round_q(last_t_reg * t_reg);
    assign new_u = round_q(last_u_reg * u_reg);

    // Round half up to Q24.24 and clip
    assign rounded = acc_reg + HALF_ACC;
    assign quot    = rounded >>> FRAC_W;
    assign sat_hi  = (quot > OUT_MAX);
    assign sat_lo  = (quot < OUT_MIN);

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign poly_value = poly_value_reg;
    assign saturated  = saturated_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_eval)
                begin
                    state_next = (degree == '0) ? ST_TERMS : ST_POWERS;
                end
            end
            ST_POWERS:
            begin
                if (n_reg == deg_reg)
                begin
                    state_next = ST_TERMS;
                end
            end
            ST_TERMS:
            begin
                if (last_term)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!(p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            p4_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            deg_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p1_v_reg  <= (state_reg == ST_TERMS);
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            p4_v_reg  <= p3_v_reg;

            if (start_eval)
            begin
                deg_reg <= degree;
                n_reg   <= DEG_W'(1);
                i_reg   <= '0;
                j_reg   <= '0;
                idx_reg <= '0;
            end
            if (state_reg == ST_POWERS)
            begin
                n_reg <= n_reg + DEG_W'(1);
            end
            if (state_reg == ST_TERMS)
            begin
                idx_reg <= idx_reg + TERM_W'(1);
                if (DEG_W'(i_reg + j_reg) == deg_reg)
                begin
                    i_reg <= i_reg + DEG_W'(1);
                    j_reg <= '0;
                end
                else
                begin
                    j_reg <= j_reg + DEG_W'(1);
                end
            end

            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_eval)
        begin
            s_reg        <= q_head.item.s;
            t_reg        <= q_head.item.t;
            u_reg        <= q_head.item.u;
            last_s_reg   <= ONE_Q;
            last_t_reg   <= ONE_Q;
            last_u_reg   <= ONE_Q;
            pow_s_reg[0] <= ONE_Q;
            pow_t_reg[0] <= ONE_Q;
            pow_u_reg[0] <= ONE_Q;
            acc_reg      <= '0;
        end

        if (state_reg == ST_POWERS)
        begin
            pow_s_reg[n_reg] <= new_s;
            pow_t_reg[n_reg] <= new_t;
            pow_u_reg[n_reg] <= new_u;
            last_s_reg       <= new_s;
            last_t_reg       <= new_t;
            last_u_reg       <= new_u;
        end

        // Issue: coefficient read goes out now, data lands with stage 2
        p1_i_reg   <= i_reg;
        p1_j_reg   <= j_reg;
        p1_k_reg   <= DEG_W'(deg_reg - i_reg - j_reg);
        p1_inr_reg <= (int'(idx_reg) < COEF_DEPTH);

        p2_prod_reg <= pow_s_reg[p1_i_reg] * pow_t_reg[p1_j_reg];
        p2_k_reg    <= p1_k_reg;
        p2_coef_reg <= p1_inr_reg ? $signed(ram_rdata) : '0;

        p3_prod_reg <= round_q(p2_prod_reg) * pow_u_reg[p2_k_reg];
        p3_coef_reg <= p2_coef_reg;

        p4_term_reg <= p3_coef_reg * $signed({1'b0, round_q(p3_prod_reg)});

        if (p4_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(p4_term_reg);
        end

        if ((state_reg == ST_FINISH) && out_free)
        begin
            saturated_reg <= sat_hi || sat_lo;
            if (sat_hi)
            begin
                poly_value_reg <= OUT_MAX[OUT_W-1:0];
            end
            else if (sat_lo)
            begin
                poly_value_reg <= OUT_MIN[OUT_W-1:0];
            end
            else
            begin
                poly_value_reg <= quot[OUT_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_poly_eval_core.sv =====
// Evaluates a homogeneous polynomial of degree poly_degree (clamped to 8) at a
// barycentric point (s, t, u), each unsigned Q1.24 and taken as 1.0 above 1.0.
// Load beats (opcode 0) write one signed Q8.24 coefficient into a 64-entry
// store and return nothing; evaluate beats (opcode 1) return one beat with
// the signed Q24.24 sum over i+j<=degree of coef[index]*s^i*t^j*u^(deg-i-j),
// index counting i outer and j inner, plus a saturation flag. A coefficient
// must be loaded before any evaluation that reads it. A load is written into
// the store as the engine takes it from the queue. An evaluation first builds
// the power tables (skipped at degree zero), then issues one term per cycle
// into a multiply pipeline (stages p1 to p4, then the accumulator) whose
// single coefficient store read port and single term multiplier set the pace.
// A two-entry queue sits ahead of the engine, and the result sits in an output
// register, so input beats keep landing while a result waits to be taken.
// Write poly_degree only when the block is idle.

`default_nettype none

module triangle_poly_eval_core
    import tpe_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // Configuration write
    input  wire logic                      cfg_we,
    input  wire logic [CFG_W-1:0]          cfg_wdata,

    // Input channel
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      opcode,
    input  wire logic [INDEX_W-1:0]        coef_index,
    input  wire logic signed [COEF_W-1:0]  coef_value,
    input  wire logic [COORD_W-1:0]        s_coord,
    input  wire logic [COORD_W-1:0]        t_coord,
    input  wire logic [COORD_W-1:0]        u_coord,

    // Result channel
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [OUT_W-1:0]        poly_value,
    output logic                           saturated
);

    logic [CFG_W-1:0]  poly_degree_reg;
    logic [DEG_W-1:0]  degree;
    tpe_queue_t        q_head;
    logic              q_pop;

    // Hold the degree register; reset to linear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_degree_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            poly_degree_reg <= cfg_wdata;
        end
    end

    // Clamp the degree to what the power tables hold
    assign degree = (int'(poly_degree_reg) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE)
                                                         : DEG_W'(poly_degree_reg);

    // Front: accept, classify, clamp coordinates, queue
    tpe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .s_coord    (s_coord),
        .t_coord    (t_coord),
        .u_coord    (u_coord),
        .q_head     (q_head),
        .q_pop      (q_pop)
    );

    // Back: store loads, run evaluations, drive the result register
    tpe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .degree     (degree),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .poly_value (poly_value),
        .saturated  (saturated)
    );

endmodule

`default_nettype wire

// ===== sim/poly_eval_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of triangle_poly_eval_core, predicts every evaluate
// beat from its own coefficient store and degree, and compares result beats.
module poly_eval_checker
    import tpe_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_W-1:0]          cfg_wdata,
    input  wire logic                      in_valid,
    input  wire logic                      in_ready,
    input  wire logic                      opcode,
    input  wire logic [INDEX_W-1:0]        coef_index,
    input  wire logic signed [COEF_W-1:0]  coef_value,
    input  wire logic [COORD_W-1:0]        s_coord,
    input  wire logic [COORD_W-1:0]        t_coord,
    input  wire logic [COORD_W-1:0]        u_coord,
    input  wire logic                      out_valid,
    input  wire logic                      out_ready,
    input  wire logic signed [OUT_W-1:0]   poly_value,
    input  wire logic                      saturated,
    output int                             fail_count,
    output int                             pending
);

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    sat;
    } poly_result_t;

    localparam longint unsigned Q_ONE  = 64'd1 << FRAC_W;
    localparam longint unsigned Q_HALF = 64'd1 << (FRAC_W - 1);
    localparam longint SUM_HI = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) << (OUT_W - 1));

    logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
    logic [CFG_W-1:0]         degree_reg;
    poly_result_t             expected_evals [$];

    function automatic longint unsigned q_mul(input longint unsigned a,
                                              input longint unsigned b);
        return (a * b + Q_HALF) >> FRAC_W;
    endfunction

    function automatic longint unsigned q_pow(input longint unsigned x, input int n);
        longint unsigned p;
        p = Q_ONE;
        repeat (n) p = q_mul(p, x);
        return p;
    endfunction

    function automatic longint unsigned sat_coord(input logic [COORD_W-1:0] x);
        return (longint'(x) > Q_ONE) ? Q_ONE : longint'(x);
    endfunction

    // Sum coef * s^i * t^j * u^k exactly in Q.48, then round to Q24.24 and clip
    function automatic poly_result_t eval_poly(input logic [COORD_W-1:0] s_in,
                                               input logic [COORD_W-1:0] t_in,
                                               input logic [COORD_W-1:0] u_in,
                                               input logic [CFG_W-1:0] deg_in);
        longint unsigned s, t, u, sp, m;
        longint          acc, q, c;
        int              deg, idx, i, j;
        poly_result_t    r;
        s   = sat_coord(s_in);
        t   = sat_coord(t_in);
        u   = sat_coord(u_in);
        deg = (deg_in > MAX_DEGREE) ? MAX_DEGREE : int'(deg_in);
        acc = 0;
        idx = 0;
        for (i = 0; i <= deg; i++) begin
            sp = q_pow(s, i);
            for (j = 0; i + j <= deg; j++) begin
                m   = q_mul(q_mul(sp, q_pow(t, j)), q_pow(u, deg - i - j));
                c   = (idx < COEF_DEPTH) ? longint'(coef_mem[idx]) : 0;
                acc = acc + c * longint'(m);
                idx++;
            end
        end
        q     = (acc + longint'(Q_HALF)) >>> FRAC_W;
        r.sat = 1'b0;
        if (q > SUM_HI) begin
            q     = SUM_HI;
            r.sat = 1'b1;
        end else if (q < SUM_LO) begin
            q     = SUM_LO;
            r.sat = 1'b1;
        end
        r.value = q[OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        poly_result_t want;
        if (!rst_n) begin
            for (int k = 0; k < COEF_DEPTH; k++) coef_mem[k] = '0;
            degree_reg = CFG_W'(1);
            expected_evals.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (cfg_we)
                degree_reg = cfg_wdata;

            if (out_valid && out_ready) begin
                if (expected_evals.size() == 0) begin
                    $display("%0t: unexpected result beat: expected nothing, got %0d sat %0b",
                             $time, poly_value, saturated);
                    fail_count++;
                end else begin
                    want = expected_evals.pop_front();
                    if (poly_value !== want.value) begin
                        $display("%0t: poly_value mismatch: expected %0d, got %0d",
                                 $time, want.value, poly_value);
                        fail_count++;
                    end
                    if (saturated !== want.sat) begin
                        $display("%0t: saturated mismatch: expected %0b, got %0b",
                                 $time, want.sat, saturated);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready) begin
                if (tpe_op_t'(opcode) == OP_EVAL)
                    expected_evals.push_back(eval_poly(s_coord, t_coord, u_coord, degree_reg));
                else if (coef_index < COEF_DEPTH)
                    coef_mem[coef_index] = coef_value;
            end

            pending = expected_evals.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

// Top of the triangle_poly_eval_core regression. It only makes stimulus and
// gives the verdict; poly_eval_checker, instantiated beside the block, does
// all prediction and comparison.
module testbench;
    import tpe_pkg::*;

    localparam logic [COORD_W-1:0] COORD_TOP = {COORD_W{1'b1}};
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_BEATS  = 134;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_W-1:0]         cfg_wdata;
    logic                     in_valid;
    logic                     in_ready;
    logic                     opcode;
    logic [INDEX_W-1:0]       coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic [COORD_W-1:0]       s_coord;
    logic [COORD_W-1:0]       t_coord;
    logic [COORD_W-1:0]       u_coord;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [OUT_W-1:0]  poly_value;
    logic                     saturated;

    int fail_count;
    int pending;

    // Stimulus state: which slots hold a loaded coefficient, the degree in
    // force, and whether the current phase runs without any idling.
    logic [COEF_DEPTH-1:0] loaded_slots;
    int                    cur_degree;
    bit                    quiet;
    int                    stall_left = 0;

    always #4 clk = ~clk;

    triangle_poly_eval_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .s_coord    (s_coord),
        .t_coord    (t_coord),
        .u_coord    (u_coord),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .poly_value (poly_value),
        .saturated  (saturated)
    );

    poly_eval_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .s_coord    (s_coord),
        .t_coord    (t_coord),
        .u_coord    (u_coord),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .poly_value (poly_value),
        .saturated  (saturated),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side back-pressure: start a random stall now and then. Hold ready
    // high in quiet phases.
    always @(negedge clk)
    begin
        if (quiet || !rst_n)
            out_ready <= 1'b1;
        else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 20) begin
            out_ready  <= 1'b0;
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(7, 39);
        end else
            out_ready <= 1'b1;
    end

    // Idle cycles after a beat: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    // Number of coefficients an evaluation reads at a given degree setting.
    function automatic int term_count(input int deg);
        int d;
        d = (deg > MAX_DEGREE) ? MAX_DEGREE : deg;
        return (d + 1) * (d + 2) / 2;
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(COEF_W - 1){1'b1}}};
            1:       return {1'b1, {(COEF_W - 1){1'b0}}};
            2:       return '1;
            3:       return $signed($urandom_range(0, 2 << FRAC_W)) - (1 << FRAC_W);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONE_Q;
            2:       return COORD_W'($urandom_range(ONE_Q + 1, COORD_TOP));
            3:       return COORD_W'($urandom);
            default: return COORD_W'($urandom_range(0, ONE_Q));
        endcase
    endfunction

    // Build a load beat; fill the unused coordinate fields with noise.
    function automatic tpe_item_t make_load(input int idx, input logic signed [COEF_W-1:0] val);
        tpe_item_t b;
        b.op    = OP_LOAD;
        b.index = INDEX_W'(idx);
        b.value = val;
        b.s     = COORD_W'($urandom);
        b.t     = COORD_W'($urandom);
        b.u     = COORD_W'($urandom);
        return b;
    endfunction

    // Build an evaluate beat; the index and value fields carry noise.
    function automatic tpe_item_t make_eval(input logic [COORD_W-1:0] s,
                                            input logic [COORD_W-1:0] t,
                                            input logic [COORD_W-1:0] u);
        tpe_item_t b;
        b.op    = OP_EVAL;
        b.index = INDEX_W'($urandom);
        b.value = $urandom;
        b.s     = s;
        b.t     = t;
        b.u     = u;
        return b;
    endfunction

    // About two in five points on the triangle (s + t + u = 1), the rest anywhere.
    function automatic tpe_item_t random_eval();
        logic [COORD_W-1:0] s, t;
        if ($urandom_range(0, 99) < 40) begin
            s = COORD_W'($urandom_range(0, ONE_Q));
            t = COORD_W'($urandom_range(0, ONE_Q - s));
            return make_eval(s, t, ONE_Q - s - t);
        end
        return make_eval(pick_coord(), pick_coord(), pick_coord());
    endfunction

    // Drive one beat at the falling edge and hold it until accepted, then, if the
    // random gap is not zero, drop valid for that gap.
    task automatic send_beat(input tpe_item_t b);
        int gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        opcode     <= b.op;
        coef_index <= b.index;
        coef_value <= b.value;
        s_coord    <= b.s;
        t_coord    <= b.t;
        u_coord    <= b.u;
        if (b.op == OP_LOAD)
            loaded_slots[b.index] = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid, wait for every expected result, then let trailing loads
    // retire before the block is considered idle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_degree(input int deg);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(deg);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_degree = deg;
    endtask

    // One random phase: load any slot the degree needs before evaluating,
    // then mix evaluations with reloads of live and spare slots.
    task automatic run_phase(input int beats);
        int nterms, first_free;
        nterms = term_count(cur_degree);
        repeat (beats) begin
            first_free = -1;
            for (int k = nterms - 1; k >= 0; k--)
                if (!loaded_slots[k]) first_free = k;
            if (first_free >= 0)
                send_beat(make_load(first_free, pick_coef()));
            else if ($urandom_range(0, 99) < 45) begin
                if ($urandom_range(0, 9) < 7)
                    send_beat(make_load($urandom_range(0, nterms - 1), pick_coef()));
                else
                    send_beat(make_load($urandom_range(0, COEF_DEPTH - 1), pick_coef()));
            end else
                send_beat(random_eval());
        end
    endtask

    // Degree settings per phase: zero, the maximum, values past the maximum
    // (clamped), and the ones in between; end back at the reset value.
    int phase_degrees [] = '{0, 8, 15, 3, 9, 5, 2, 7, 4, 6, 8, 12, 1};

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        opcode       = OP_LOAD;
        coef_index   = '0;
        coef_value   = '0;
        s_coord      = '0;
        t_coord      = '0;
        u_coord      = '0;
        loaded_slots = '0;
        cur_degree   = 1;
        quiet        = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed beats at the reset degree of one (three terms): extreme
        // coefficients, the corners, the origin, coordinates above one, the
        // centroid, and a slot the degree never reads.
        send_beat(make_load(0, {1'b0, {(COEF_W - 1){1'b1}}}));
        send_beat(make_load(1, {1'b1, {(COEF_W - 1){1'b0}}}));
        send_beat(make_load(2, 32'sd1 << FRAC_W));
        send_beat(make_eval(ONE_Q, '0, '0));
        send_beat(make_eval('0, ONE_Q, '0));
        send_beat(make_eval('0, '0, ONE_Q));
        send_beat(make_eval('0, '0, '0));
        send_beat(make_eval(COORD_TOP, COORD_TOP, COORD_TOP));
        send_beat(make_eval(ONE_Q + COORD_W'(1), '0, COORD_TOP));
        send_beat(make_eval(25'd5592405, 25'd5592405, 25'd5592406));
        send_beat(make_load(COEF_DEPTH - 1, '1));
        send_beat(make_load(2, '1));
        send_beat(make_load(0, '0));
        send_beat(make_eval(25'd5592405, 25'd5592405, 25'd5592406));
        send_beat(make_eval(ONE_Q >> 1, '0, ONE_Q >> 1));
        send_beat(make_eval(ONE_Q - COORD_W'(1), 25'd1, '0));

        // Random phases, each at its own degree; about one in four with no
        // idling on either side.
        foreach (phase_degrees[p]) begin
            write_degree(phase_degrees[p]);
            quiet = ($urandom_range(0, 3) == 0);
            run_phase(PHASE_BEATS);
        end

        drain();
        if (fail_count == 0)
            $display("triangle_poly_eval_core regression: pass");
        else
            $display("triangle_poly_eval_core regression: fail");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #20000000;
        $display("triangle_poly_eval_core regression: fail");
        $finish;
    end

endmodule
